/* rtl/core/msseq_pkg.sv */
// shared types, constants and the quadrature table of the step sequencer input unit
`timescale 1ns / 1ps

package msseq_pkg;

    localparam int NUM_SLOTS = 8;
    localparam logic [2:0] LAST_SLOT = 3'(NUM_SLOTS - 1);

    // configuration register reset values
    localparam logic [7:0] DEBOUNCE_RESET      = 8'd30;
    localparam logic [8:0] TEMPO_MIN_RESET     = 9'd60;
    localparam logic [8:0] TEMPO_MAX_RESET     = 9'd360;
    localparam logic [8:0] TEMPO_DEFAULT_RESET = 9'd120;
    localparam logic [8:0] TEMPO_RESET         = 9'd120;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE      = 2'd0,
        CFG_TEMPO_MIN     = 2'd1,
        CFG_TEMPO_MAX     = 2'd2,
        CFG_TEMPO_DEFAULT = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FIRST,
        ST_EMIT
    } ctrl_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic       capture;
        logic       update;
        logic       load;
        logic       first;
        logic [2:0] slot;
    } cmd_t;

    // x4 decode table indexed by {prev a, prev b, cur a, cur b}
    function automatic logic signed [1:0] quad_delta(input logic [3:0] idx);
        logic signed [1:0] d;
        case (idx)
            4'd1, 4'd7, 4'd8, 4'd14: d = -2'sd1;
            4'd2, 4'd4, 4'd11, 4'd13: d = 2'sd1;
            default: d = 2'sd0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/msseq_ctrl.sv */
// controller state machine of the step sequencer input unit
`timescale 1ns / 1ps

module msseq_ctrl
    import msseq_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  logic out_stall,
    output cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic [2:0]  slot_reg, slot_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            slot_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        slot_next   = slot_reg;
        in_stall    = 1'b1;
        out_valid   = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                cmd.load   = 1'b1;
                cmd.first  = 1'b1;
                cmd.slot   = '0;
                slot_next  = '0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    if (slot_reg == LAST_SLOT)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.load  = 1'b1;
                        cmd.slot  = slot_reg + 3'd1;
                        slot_next = slot_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // a captured sample shows its first word after the update and first-load states
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |-> ##3 out_valid)
        else $error("first word not shown after sample");

    // no sample is taken while a word is pending
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid)
        else $error("sample taken during emission");

    // a taken word that is not the last is followed by the next slot
    a_slot_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && slot_reg != LAST_SLOT) |=>
        (out_valid && slot_reg == $past(slot_reg) + 3'd1))
        else $error("slot did not advance");

    // after the last word the unit is ready again
    a_run_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && slot_reg == LAST_SLOT) |=> (!out_valid && !in_stall))
        else $error("run did not end after last slot");

endmodule

/* rtl/core/msseq_datapath.sv */
// datapath of the step sequencer input unit: decode, buttons, positions and output words
`timescale 1ns / 1ps

module msseq_datapath
    import msseq_pkg::*;
#(
    parameter int CHIP0_ENCODERS  = 5,
    parameter int CHIP1_ENCODERS  = 4,
    parameter int BUTTON_BASE_PIN = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    input  logic               expander_sel,
    input  logic [15:0]        port_bits,
    input  logic [31:0]        now_ms,
    output logic [2:0]         step_slot,
    output logic signed [31:0] step_value,
    output logic               step_on,
    output logic [8:0]         tempo,
    output logic               run_end
);

    localparam int ENC_TOTAL = CHIP0_ENCODERS + CHIP1_ENCODERS;
    localparam int STEP_ENC  = ENC_TOTAL - 1;

    // configuration
    logic [7:0] debounce_reg;
    logic [8:0] tempo_min_reg, tempo_max_reg, tempo_default_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg      <= DEBOUNCE_RESET;
            tempo_min_reg     <= TEMPO_MIN_RESET;
            tempo_max_reg     <= TEMPO_MAX_RESET;
            tempo_default_reg <= TEMPO_DEFAULT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_DEBOUNCE:      debounce_reg      <= cfg_data[7:0];
                CFG_TEMPO_MIN:     tempo_min_reg     <= cfg_data;
                CFG_TEMPO_MAX:     tempo_max_reg     <= cfg_data;
                CFG_TEMPO_DEFAULT: tempo_default_reg <= cfg_data;
                default:           debounce_reg      <= debounce_reg;
            endcase
        end
    end

    // captured sample
    logic        sel_reg;
    logic [15:0] port_reg;
    logic [31:0] now_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sel_reg  <= expander_sel;
            port_reg <= port_bits;
            now_reg  <= now_ms;
        end
    end

    // encoder state
    logic [15:0]        prev_port_reg   [2];
    logic               prev_button_reg [ENC_TOTAL];
    logic [31:0]        press_time_reg  [ENC_TOTAL];
    logic signed [31:0] position_reg    [STEP_ENC];
    logic               enabled_reg     [STEP_ENC];
    logic [8:0]         tempo_reg;

    logic signed [1:0] tempo_delta;
    logic              tempo_hit, tempo_press;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_port_reg[0] <= '1;
            prev_port_reg[1] <= '1;
        end
        else if (cmd.update)
        begin
            prev_port_reg[sel_reg] <= port_reg;
        end
    end

    for (genvar g = 0; g < ENC_TOTAL; g++)
    begin : g_enc
        localparam int CHIP = (g < CHIP0_ENCODERS) ? 0 : 1;
        localparam int R    = (g < CHIP0_ENCODERS) ? g : g - CHIP0_ENCODERS;
        localparam int PA   = 2 * R;
        localparam int PB   = 2 * R + 1;
        localparam int PBTN = (BUTTON_BASE_PIN + R) % 16;

        logic [3:0]        qidx;
        logic signed [1:0] delta;
        logic              btn, hit, press;
        logic [31:0]       elapsed;

        assign qidx    = {prev_port_reg[CHIP][PA], prev_port_reg[CHIP][PB],
                          port_reg[PA], port_reg[PB]};
        assign delta   = quad_delta(qidx);
        assign btn     = port_reg[PBTN];
        assign hit     = cmd.update && (sel_reg == 1'(CHIP));
        assign elapsed = now_reg - press_time_reg[g];
        // falling edge, outside the debounce window
        assign press   = hit && !btn && prev_button_reg[g] &&
                         (elapsed > {24'd0, debounce_reg});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                prev_button_reg[g] <= 1'b1;
                press_time_reg[g]  <= '0;
            end
            else
            begin
                if (hit)
                begin
                    prev_button_reg[g] <= btn;
                end
                if (press)
                begin
                    press_time_reg[g] <= now_reg;
                end
            end
        end

        if (g == 0)
        begin : g_tempo
            assign tempo_delta = delta;
            assign tempo_hit   = hit;
            assign tempo_press = press;
        end
        else
        begin : g_step
            logic signed [31:0] pos_sum;
            logic               pos_hold;

            assign pos_sum  = position_reg[g-1] + {{30{delta[1]}}, delta};
            // saturate at the signed 32-bit limits
            assign pos_hold = (delta == 2'sd1 && position_reg[g-1] == 32'sh7fffffff) ||
                              (delta == -2'sd1 && position_reg[g-1] == 32'sh80000000);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    position_reg[g-1] <= '0;
                    enabled_reg[g-1]  <= 1'b1;
                end
                else
                begin
                    if (hit && enabled_reg[g-1] && !pos_hold)
                    begin
                        position_reg[g-1] <= pos_sum;
                    end
                    if (press)
                    begin
                        enabled_reg[g-1] <= !enabled_reg[g-1];
                    end
                end
            end
        end
    end

    // tempo: step and clamp, a button press restores the default unclamped
    logic signed [10:0] tempo_sum;
    logic [8:0]         tempo_clamped;

    assign tempo_sum = $signed({2'b00, tempo_reg}) + {{9{tempo_delta[1]}}, tempo_delta};

    always_comb
    begin
        if (tempo_sum < $signed({2'b00, tempo_min_reg}))
        begin
            tempo_clamped = tempo_min_reg;
        end
        else if (tempo_sum > $signed({2'b00, tempo_max_reg}))
        begin
            tempo_clamped = tempo_max_reg;
        end
        else
        begin
            tempo_clamped = tempo_sum[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tempo_reg <= TEMPO_RESET;
        end
        else if (tempo_press)
        begin
            tempo_reg <= tempo_default_reg;
        end
        else if (tempo_hit)
        begin
            tempo_reg <= tempo_clamped;
        end
    end

    // per slot view, slot k shows encoder k+1
    logic               slot_on  [NUM_SLOTS];
    logic signed [31:0] slot_pos [NUM_SLOTS];

    for (genvar k = 0; k < NUM_SLOTS; k++)
    begin : g_slot
        if (k < STEP_ENC)
        begin : g_real
            assign slot_on[k]  = enabled_reg[k];
            assign slot_pos[k] = position_reg[k];
        end
        else
        begin : g_none
            assign slot_on[k]  = 1'b0;
            assign slot_pos[k] = '0;
        end
    end

    // output word; the value register also carries the last enabled value
    logic [2:0]         step_slot_reg;
    logic signed [31:0] step_value_reg;
    logic               step_on_reg, run_end_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            step_slot_reg <= cmd.slot;
            step_on_reg   <= slot_on[cmd.slot];
            run_end_reg   <= (cmd.slot == LAST_SLOT);
            if (slot_on[cmd.slot])
            begin
                step_value_reg <= slot_pos[cmd.slot];
            end
            else if (cmd.first)
            begin
                step_value_reg <= '0;
            end
        end
    end

    assign step_slot  = step_slot_reg;
    assign step_value = step_value_reg;
    assign step_on    = step_on_reg;
    assign run_end    = run_end_reg;
    assign tempo      = tempo_reg;

endmodule

/* rtl/core/multi_encoder_step_sequencer_input_unit.sv */
// top level of the multi encoder step sequencer input unit
`timescale 1ns / 1ps

// takes one 16-bit port word from one of two expanders together with a millisecond
// timestamp, x4-decodes the a/b pin pairs of that expander's encoders, steps the clamped
// tempo (encoder 0) or the saturating positions of enabled encoders, handles debounced
// active-low button presses (tempo default or enable toggle), then emits eight step
// words for encoders 1..8, run_end marking the eighth. a sample passes through accept,
// an update step in which all encoders of the sampled expander are handled in parallel,
// a load of slot 0, then one emitted word per cycle while the output is not stalled.
// input stall stays high from accept until the last word is taken. configuration
// writes are applied at once and belong to idle periods.
module multi_encoder_step_sequencer_input_unit
    import msseq_pkg::*;
#(
    parameter int CHIP0_ENCODERS  = 5,
    parameter int CHIP1_ENCODERS  = 4,
    parameter int BUTTON_BASE_PIN = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    // configuration write port
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    // sample channel
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               expander_sel,
    input  logic [15:0]        port_bits,
    input  logic [31:0]        now_ms,
    // step word channel
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         step_slot,
    output logic signed [31:0] step_value,
    output logic               step_on,
    output logic [8:0]         tempo,
    output logic               run_end
);

    cmd_t cmd;

    // sequencer: capture, update, then one load per slot
    msseq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    // encoder state, config registers and output word register
    msseq_datapath #(
        .CHIP0_ENCODERS  (CHIP0_ENCODERS),
        .CHIP1_ENCODERS  (CHIP1_ENCODERS),
        .BUTTON_BASE_PIN (BUTTON_BASE_PIN)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .expander_sel (expander_sel),
        .port_bits    (port_bits),
        .now_ms       (now_ms),
        .step_slot    (step_slot),
        .step_value   (step_value),
        .step_on      (step_on),
        .tempo        (tempo),
        .run_end      (run_end)
    );

endmodule
